### design/sbo_pkg.sv
// ----------------------------------------------------------------------------
// sbo_pkg
// Shared types and constants for the segment / box overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package sbo_pkg;

  localparam int TOL_BITS      = 20;
  localparam int CFG_IDX_BITS  = 1;
  localparam int OUT_DATA_BITS = 8;
  localparam int NUM_FIELDS    = 12;
  localparam int HIT_BIT       = 0;
  localparam int EMPTY_BIT     = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GROW_TOL  = 1'b0,
    REG_EMPTY_EPS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic empty;
    logic axis_sep;
  } prep_flags_t;

endpackage

`default_nettype wire

### design/segment_box_overlap_test_top.sv
// ----------------------------------------------------------------------------
// segment_box_overlap_test_top
// Segment versus tolerance-grown axis-aligned box, separating-axis test.
// ----------------------------------------------------------------------------
// Pipeline: input register, axis stage, product registers, output register.
// Throughput: one item per cycle; each stage advances when the next has room.
// Reset: synchronous; clears all valid flags and both config registers to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_box_overlap_test_top #(
  parameter int COORD_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [sbo_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [sbo_pkg::TOL_BITS-1:0]           cfg_data,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // box_min_x/y/z, box_max_x/y/z, seg_start_x/y/z, seg_end_x/y/z, zero pad
  input  logic [((sbo_pkg::NUM_FIELDS*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // hit, box_empty, zero pad
  output logic [sbo_pkg::OUT_DATA_BITS-1:0]      m_tdata
);

  localparam int MW  = COORD_BITS + 2;
  localparam int DW  = COORD_BITS + 1;
  localparam int EW0 = (COORD_BITS + 1 > sbo_pkg::TOL_BITS + 3) ?
                       COORD_BITS + 1 : sbo_pkg::TOL_BITS + 3;
  localparam int EW  = EW0 + 1;

  logic [sbo_pkg::TOL_BITS-1:0] grow_tolerance;
  logic [sbo_pkg::TOL_BITS-1:0] empty_epsilon;

  logic v0, v1, v2;
  logic ld0, ld1, ld2, ld3;

  logic signed [COORD_BITS-1:0] box_min   [3];
  logic signed [COORD_BITS-1:0] box_max   [3];
  logic signed [COORD_BITS-1:0] seg_start [3];
  logic signed [COORD_BITS-1:0] seg_end   [3];

  logic signed [MW-1:0] mid2_c [3];
  logic signed [DW-1:0] dir2_c [3];
  logic signed [EW-1:0] ext2_c [3];
  sbo_pkg::prep_flags_t flags_c;

  logic signed [MW-1:0] mid2 [3];
  logic signed [DW-1:0] dir2 [3];
  logic signed [EW-1:0] ext2 [3];
  sbo_pkg::prep_flags_t flags1;
  sbo_pkg::prep_flags_t flags2;

  logic [2:0] cross_sep;
  logic       hit;
  logic       box_empty;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      grow_tolerance <= '0;
      empty_epsilon  <= '0;
    end else if (cfg_we) begin
      case (sbo_pkg::cfg_reg_t'(cfg_index))
        sbo_pkg::REG_GROW_TOL:  grow_tolerance <= cfg_data;
        sbo_pkg::REG_EMPTY_EPS: empty_epsilon  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage flow control
  assign ld3 = !m_tvalid || m_tready;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign ld0 = !v0 || ld1;
  assign s_tready = ld0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ld0) v0 <= s_tvalid;
      if (ld1) v1 <= v0;
      if (ld2) v2 <= v1;
      if (ld3) m_tvalid <= v2;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (ld0) begin
      for (int i = 0; i < 3; i++) begin
        box_min[i]   <= s_tdata[i*COORD_BITS +: COORD_BITS];
        box_max[i]   <= s_tdata[(3+i)*COORD_BITS +: COORD_BITS];
        seg_start[i] <= s_tdata[(6+i)*COORD_BITS +: COORD_BITS];
        seg_end[i]   <= s_tdata[(9+i)*COORD_BITS +: COORD_BITS];
      end
    end
  end

  sbo_prep #(
    .COORD_BITS (COORD_BITS),
    .MW         (MW),
    .DW         (DW),
    .EW         (EW)
  ) u_prep (
    .box_min        (box_min),
    .box_max        (box_max),
    .seg_start      (seg_start),
    .seg_end        (seg_end),
    .grow_tolerance (grow_tolerance),
    .empty_epsilon  (empty_epsilon),
    .mid2           (mid2_c),
    .dir2           (dir2_c),
    .ext2           (ext2_c),
    .flags          (flags_c)
  );

  always_ff @(posedge clk) begin
    if (ld1) begin
      mid2   <= mid2_c;
      dir2   <= dir2_c;
      ext2   <= ext2_c;
      flags1 <= flags_c;
    end
    if (ld2) flags2 <= flags1;
  end

  // axes y x z, z x x, x x y
  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int A = (k + 1) % 3;
    localparam int B = (k + 2) % 3;
    sbo_cross #(
      .MW (MW),
      .DW (DW),
      .EW (EW)
    ) u_cross (
      .clk   (clk),
      .en    (ld2),
      .mid_a (mid2[A]),
      .mid_b (mid2[B]),
      .dir_a (dir2[A]),
      .dir_b (dir2[B]),
      .ext_a (ext2[A]),
      .ext_b (ext2[B]),
      .sep   (cross_sep[k])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (ld3) begin
      hit       <= !flags2.empty && !flags2.axis_sep && !(|cross_sep);
      box_empty <= flags2.empty;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[sbo_pkg::HIT_BIT]   = hit;
    m_tdata[sbo_pkg::EMPTY_BIT] = box_empty;
  end

endmodule

`default_nettype wire

### design/sbo_prep.sv
// ----------------------------------------------------------------------------
// sbo_prep
// Doubled centers and extents, empty-box check and the three world-axis tests.
// ----------------------------------------------------------------------------
`default_nettype none

module sbo_prep #(
  parameter int COORD_BITS = 24,
  parameter int MW = COORD_BITS + 2,
  parameter int DW = COORD_BITS + 1,
  parameter int EW = 24
) (
  input  logic signed [COORD_BITS-1:0]   box_min   [3],
  input  logic signed [COORD_BITS-1:0]   box_max   [3],
  input  logic signed [COORD_BITS-1:0]   seg_start [3],
  input  logic signed [COORD_BITS-1:0]   seg_end   [3],
  input  logic        [sbo_pkg::TOL_BITS-1:0] grow_tolerance,
  input  logic        [sbo_pkg::TOL_BITS-1:0] empty_epsilon,
  output logic signed [MW-1:0]           mid2      [3],
  output logic signed [DW-1:0]           dir2      [3],
  output logic signed [EW-1:0]           ext2      [3],
  output sbo_pkg::prep_flags_t           flags
);

  localparam int TW = EW + 1;

  logic signed [EW-1:0] tol2;
  logic signed [EW-1:0] eps_s;
  logic [2:0] empty_ax;
  logic [2:0] sep_ax;

  assign tol2  = $signed({{(EW-sbo_pkg::TOL_BITS-1){1'b0}}, grow_tolerance, 1'b0});
  assign eps_s = $signed({{(EW-sbo_pkg::TOL_BITS){1'b0}}, empty_epsilon});

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic        [MW-1:0] abs_m;
    logic        [DW-1:0] abs_d;
    logic signed [TW-1:0] bound;

    assign mid2[i] = MW'(seg_start[i]) + MW'(seg_end[i]) - MW'(box_min[i]) - MW'(box_max[i]);
    assign dir2[i] = DW'(seg_end[i]) - DW'(seg_start[i]);
    assign ext2[i] = EW'(box_max[i]) - EW'(box_min[i]) + tol2;

    assign empty_ax[i] = EW'(box_min[i]) > (EW'(box_max[i]) + eps_s);

    assign abs_m = mid2[i][MW-1] ? MW'(-mid2[i]) : MW'(mid2[i]);
    assign abs_d = dir2[i][DW-1] ? DW'(-dir2[i]) : DW'(dir2[i]);
    assign bound = TW'(ext2[i]) + $signed({{(TW-DW){1'b0}}, abs_d});
    assign sep_ax[i] = $signed({{(TW-MW){1'b0}}, abs_m}) > bound;
  end

  assign flags.empty    = |empty_ax;
  assign flags.axis_sep = |sep_ax;

endmodule

`default_nettype wire

### design/sbo_cross.sv
// ----------------------------------------------------------------------------
// sbo_cross
// One cross-product separating axis: registered products, then compare.
// ----------------------------------------------------------------------------
`default_nettype none

module sbo_cross #(
  parameter int MW = 26,
  parameter int DW = 25,
  parameter int EW = 26
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [MW-1:0] mid_a,
  input  logic signed [MW-1:0] mid_b,
  input  logic signed [DW-1:0] dir_a,
  input  logic signed [DW-1:0] dir_b,
  input  logic signed [EW-1:0] ext_a,
  input  logic signed [EW-1:0] ext_b,
  output logic                 sep
);

  localparam int PM = MW + DW;
  localparam int PE = EW + DW + 1;
  localparam int LW = PM + 1;
  localparam int CW = PE + 1;

  logic        [DW-1:0] abs_a;
  logic        [DW-1:0] abs_b;
  logic signed [PM-1:0] prod_ab;
  logic signed [PM-1:0] prod_ba;
  logic signed [PE-1:0] prod_ea;
  logic signed [PE-1:0] prod_eb;
  logic signed [LW-1:0] diff;
  logic        [LW-1:0] lhs;
  logic signed [CW-1:0] rhs;

  assign abs_a = dir_a[DW-1] ? DW'(-dir_a) : DW'(dir_a);
  assign abs_b = dir_b[DW-1] ? DW'(-dir_b) : DW'(dir_b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_ab <= PM'(mid_a) * PM'(dir_b);
      prod_ba <= PM'(mid_b) * PM'(dir_a);
      prod_ea <= PE'(ext_a) * PE'($signed({1'b0, abs_b}));
      prod_eb <= PE'(ext_b) * PE'($signed({1'b0, abs_a}));
    end
  end

  // |ma*db - mb*da| > ea*|db| + eb*|da|
  assign diff = LW'(prod_ab) - LW'(prod_ba);
  assign lhs  = diff[LW-1] ? LW'(-diff) : LW'(diff);
  assign rhs  = CW'(prod_ea) + CW'(prod_eb);
  assign sep  = $signed({{(CW-LW){1'b0}}, lhs}) > rhs;

endmodule

`default_nettype wire

### design/sbo_checker.sv
// ----------------------------------------------------------------------------
// sbo_checker
// Port-level checks on the result stream and on s_tready, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbo_checker (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tready,
  input  wire                                m_tvalid,
  input  wire                                m_tready,
  input  wire [sbo_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_hit_not_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[sbo_pkg::HIT_BIT] && m_tdata[sbo_pkg::EMPTY_BIT]))
    else $error("hit reported on an empty box");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with output register free");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[sbo_pkg::OUT_DATA_BITS-1:sbo_pkg::EMPTY_BIT+1] == '0)
    else $error("nonzero pad bits in result");

endmodule

bind segment_box_overlap_test_top sbo_checker u_sbo_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

### bench/tb_segment_box_overlap_test_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_box_overlap_test_top
// Self-checking bench for the segment versus grown-box overlap test.
// Directed boxes and segments cover the coordinate extremes, empty and
// slightly inverted boxes, point segments, touching contact and misses that
// only the cross-product axes find. Random boxes follow, with segments placed
// around them at many scales and a share of noise. The configuration is
// changed between phases. A scoreboard predicts hit and box_empty for every
// input transfer and checks each result transfer in order. Both stream sides
// stall at random.
// ----------------------------------------------------------------------------

module tb_segment_box_overlap_test_top;

  localparam int CB          = 24;
  localparam int LATENCY     = 4;
  localparam int CYCLE_LIMIT = 300000;
  localparam int F_MIN       = 0;
  localparam int F_MAX       = 3;
  localparam int F_START     = 6;
  localparam int F_END       = 9;
  localparam longint C_MAX   = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint C_MIN   = -(64'sd1 <<< (CB - 1));
  localparam int TOL_MAX     = (1 << sbo_pkg::TOL_BITS) - 1;

  typedef logic [CB-1:0] coord_t;
  typedef logic [sbo_pkg::NUM_FIELDS-1:0][CB-1:0] box_seg_t;

  typedef struct {
    logic hit;
    logic box_empty;
  } verdict_t;

  class overlap_scoreboard;
    longint      grow_tol;
    longint      empty_eps;
    verdict_t    pending_verdicts[$];
    int unsigned mismatches;

    function new();
      grow_tol   = 0;
      empty_eps  = 0;
      mismatches = 0;
    endfunction

    function void set_reg(sbo_pkg::cfg_reg_t idx, logic [sbo_pkg::TOL_BITS-1:0] val);
      case (idx)
        sbo_pkg::REG_GROW_TOL: begin
          grow_tol = val;
        end
        sbo_pkg::REG_EMPTY_EPS: begin
          empty_eps = val;
        end
        default: begin
        end
      endcase
    endfunction

    function longint mag(longint x);
      return (x < 0) ? -x : x;
    endfunction

    // |m1*d2 - m2*d1| > e1*|d2| + e2*|d1|
    function bit cross_apart(longint m1, longint m2, longint d1, longint d2,
                             longint e1, longint e2);
      logic signed [127:0] wm1, wm2, wd1, wd2, we1, we2, lhs, rhs;
      wm1 = m1;
      wm2 = m2;
      wd1 = mag(d1);
      wd2 = mag(d2);
      we1 = e1;
      we2 = e2;
      lhs = wm1 * $signed(128'(d2)) - wm2 * $signed(128'(d1));
      if (lhs < 0) lhs = -lhs;
      rhs = we1 * wd2 + we2 * wd1;
      return lhs > rhs;
    endfunction

    function verdict_t overlap_predict(box_seg_t it);
      longint   lo[3], hi[3], st[3], en[3];
      longint   ext[3], mid[3], dir[3];
      verdict_t v;
      v.hit       = 1'b1;
      v.box_empty = 1'b0;
      for (int i = 0; i < 3; i++) begin
        lo[i] = $signed(it[F_MIN + i]);
        hi[i] = $signed(it[F_MAX + i]);
        st[i] = $signed(it[F_START + i]);
        en[i] = $signed(it[F_END + i]);
        if (lo[i] > hi[i] + empty_eps) v.box_empty = 1'b1;
      end
      if (v.box_empty) begin
        v.hit = 1'b0;
        return v;
      end
      for (int i = 0; i < 3; i++) begin
        ext[i] = hi[i] - lo[i] + 2 * grow_tol;
        mid[i] = st[i] + en[i] - (lo[i] + hi[i]);
        dir[i] = en[i] - st[i];
        if (mag(mid[i]) > ext[i] + mag(dir[i])) v.hit = 1'b0;
      end
      if (v.hit && cross_apart(mid[1], mid[2], dir[1], dir[2], ext[1], ext[2]))
        v.hit = 1'b0;
      if (v.hit && cross_apart(mid[2], mid[0], dir[2], dir[0], ext[2], ext[0]))
        v.hit = 1'b0;
      if (v.hit && cross_apart(mid[0], mid[1], dir[0], dir[1], ext[0], ext[1]))
        v.hit = 1'b0;
      return v;
    endfunction

    function void note_box_transfer(box_seg_t it);
      pending_verdicts.push_back(overlap_predict(it));
    endfunction

    function void check_verdict(logic [sbo_pkg::OUT_DATA_BITS-1:0] data);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %b",
                 $time, data);
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (data[sbo_pkg::HIT_BIT] !== want.hit) begin
        $display("%0t: hit mismatch, expected %b, actual %b",
                 $time, want.hit, data[sbo_pkg::HIT_BIT]);
        mismatches++;
      end
      if (data[sbo_pkg::EMPTY_BIT] !== want.box_empty) begin
        $display("%0t: box_empty mismatch, expected %b, actual %b",
                 $time, want.box_empty, data[sbo_pkg::EMPTY_BIT]);
        mismatches++;
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst       = 1'b1;
  logic                                cfg_we    = 1'b0;
  sbo_pkg::cfg_reg_t                   cfg_index = sbo_pkg::REG_GROW_TOL;
  logic [sbo_pkg::TOL_BITS-1:0]        cfg_data  = '0;
  logic                                s_tvalid  = 1'b0;
  logic                                s_tready;
  box_seg_t                            s_tdata   = '0;
  logic                                m_tvalid;
  logic                                m_tready  = 1'b0;
  logic [sbo_pkg::OUT_DATA_BITS-1:0]   m_tdata;

  bit                idle_en = 1'b1;
  int unsigned       cycles  = 0;
  overlap_scoreboard sb;

  segment_box_overlap_test_top #(
    .COORD_BITS(CB)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic coord_t clamp_coord(longint v);
    if (v > C_MAX) return coord_t'(C_MAX);
    if (v < C_MIN) return coord_t'(C_MIN);
    return coord_t'(v);
  endfunction

  function automatic box_seg_t shape(longint mnx, longint mny, longint mnz,
                                     longint mxx, longint mxy, longint mxz,
                                     longint sx, longint sy, longint sz,
                                     longint ex, longint ey, longint ez);
    box_seg_t it;
    it[F_MIN + 0]   = clamp_coord(mnx);
    it[F_MIN + 1]   = clamp_coord(mny);
    it[F_MIN + 2]   = clamp_coord(mnz);
    it[F_MAX + 0]   = clamp_coord(mxx);
    it[F_MAX + 1]   = clamp_coord(mxy);
    it[F_MAX + 2]   = clamp_coord(mxz);
    it[F_START + 0] = clamp_coord(sx);
    it[F_START + 1] = clamp_coord(sy);
    it[F_START + 2] = clamp_coord(sz);
    it[F_END + 0]   = clamp_coord(ex);
    it[F_END + 1]   = clamp_coord(ey);
    it[F_END + 2]   = clamp_coord(ez);
    return it;
  endfunction

  task automatic program_regs(int unsigned tol, int unsigned eps);
    cfg_we    <= 1'b1;
    cfg_index <= sbo_pkg::REG_GROW_TOL;
    cfg_data  <= tol[sbo_pkg::TOL_BITS-1:0];
    @(posedge clk);
    sb.set_reg(sbo_pkg::REG_GROW_TOL, tol[sbo_pkg::TOL_BITS-1:0]);
    cfg_index <= sbo_pkg::REG_EMPTY_EPS;
    cfg_data  <= eps[sbo_pkg::TOL_BITS-1:0];
    @(posedge clk);
    sb.set_reg(sbo_pkg::REG_EMPTY_EPS, eps[sbo_pkg::TOL_BITS-1:0]);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_box(box_seg_t it);
    s_tdata  <= it;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_box_transfer(it);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // sender holds off until every expected result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_verdict(m_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    box_seg_t directed[$];
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    program_regs(0, 4);

    directed.push_back(shape(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(shape(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                             C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    directed.push_back(shape(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                             C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    directed.push_back(shape(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                             C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
    directed.push_back(shape(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                             C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    // empty box
    directed.push_back(shape(C_MAX, 0, 0, C_MIN, 0, 0, 0, 0, 0, 0, 0, 0));
    // inverted within epsilon, then just past it
    directed.push_back(shape(0, 11, 0, 10, 7, 10, 5, 9, 5, 5, 9, 5));
    directed.push_back(shape(0, 0, 12, 10, 10, 7, 5, 5, 9, 5, 5, 9));
    directed.push_back(shape(4, 4, 4, 0, 0, 0, 2, 2, 2, 2, 2, 2));
    // point segments inside, outside and on the face
    directed.push_back(shape(0, 0, 0, 10, 10, 10, 5, 5, 5, 5, 5, 5));
    directed.push_back(shape(0, 0, 0, 10, 10, 10, 11, 5, 5, 11, 5, 5));
    directed.push_back(shape(0, 0, 0, 10, 10, 10, 10, 5, 5, 10, 5, 5));
    // cross-axis miss and corner touch in each plane
    directed.push_back(shape(0, 0, 0, 10, 10, 10, 30, -5, 5, -5, 30, 5));
    directed.push_back(shape(0, 0, 0, 10, 10, 10, 25, -5, 5, -5, 25, 5));
    directed.push_back(shape(0, 0, 0, 10, 10, 10, 5, 30, -5, 5, -5, 30));
    directed.push_back(shape(0, 0, 0, 10, 10, 10, 5, 25, -5, 5, -5, 25));
    directed.push_back(shape(0, 0, 0, 10, 10, 10, -5, 5, 30, 30, 5, -5));
    directed.push_back(shape(0, 0, 0, 10, 10, 10, -5, 5, 25, 25, 5, -5));
    // long segments
    directed.push_back(shape(-100, -100, -100, 100, 100, 100,
                             C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
    directed.push_back(shape(-100, -100, -100, 100, 100, 100,
                             C_MIN, C_MAX, 0, C_MAX, C_MIN, 0));
    directed.push_back(shape(0, 0, 0, 10, 10, 10, C_MIN, 20, 5, C_MAX, 20, 5));
    foreach (directed[j]) send_box(directed[j]);
    settle();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: program_regs(0, 0);
        1: program_regs(TOL_MAX, TOL_MAX);
        3: program_regs(TOL_MAX, 0);
        4: program_regs(0, TOL_MAX);
        5: program_regs($urandom_range(1, 64), $urandom_range(1, 64));
        default: program_regs($urandom, $urandom);
      endcase
      idle_en = (phase != 6);
      for (int n = 0; n < 119; n++) begin : make_item
        box_seg_t it;
        int       kind;
        longint   span, c, lo, hi, sp;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
          for (int i = 0; i < sbo_pkg::NUM_FIELDS; i++) it[i] = coord_t'($urandom);
        end else begin
          span = 64'sd1 <<< $urandom_range(1, CB - 1);
          for (int a = 0; a < 3; a++) begin
            c = $signed(coord_t'($urandom));
            if ($urandom_range(0, 9) == 0) c = ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
            lo = c - longint'($urandom_range(0, 32'(span)));
            hi = lo + longint'($urandom_range(0, 32'(span)));
            if (kind < 20 && a == 0)
              hi = lo - longint'($urandom_range(0, 32'(sb.empty_eps + 8)));
            it[F_MIN + a] = clamp_coord(lo);
            it[F_MAX + a] = clamp_coord(hi);
            sp = c + longint'($urandom_range(0, 32'(4 * span))) - 2 * span;
            it[F_START + a] = clamp_coord(sp);
            if (kind % 10 == 0)
              it[F_END + a] = clamp_coord(sp);
            else
              it[F_END + a] = clamp_coord(c + longint'($urandom_range(0, 32'(4 * span)))
                                          - 2 * span);
          end
        end
        send_box(it);
      end
      settle();
    end

    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
